// ===== hdl/lph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and codes for the linear probing hash map.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam logic [1:0] OP_GET   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_ERASE = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam int KEY_W   = 32;
  localparam int HASH_W  = 32;
  localparam int VALUE_W = 64;
  localparam int LIMIT_W = 6;
  localparam int COUNT_W = 7;

  // request as queued between front and back
  typedef struct packed {
    logic               probe;   // needs a table walk
    logic [1:0]         op;
    logic [KEY_W-1:0]   key;
    logic [HASH_W-1:0]  hash;
    logic [VALUE_W-1:0] wval;
  } lph_req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK
  } lph_state_t;

endpackage

// ===== hdl/lph_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lph_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_front
// Accepts request beats, marks which need a table walk, and holds them in a
// two-entry queue for the probe engine.
// ----------------------------------------------------------------------------
module lph_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           enable,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [lph_pkg::KEY_W-1:0]      in_key,
  input  logic [lph_pkg::HASH_W-1:0]     in_hash,
  input  logic [lph_pkg::VALUE_W-1:0]    in_wval,
  output logic                           q_valid,
  input  logic                           q_pop,
  output lph_pkg::lph_req_t              q_item
);

  lph_pkg::lph_req_t entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  lph_pkg::lph_req_t item;

  assign in_ready = enable && (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  always_comb begin
    item.op    = in_op;
    item.key   = in_key;
    item.hash  = in_hash;
    item.wval  = in_wval;
    // zero key and the unused op code give an empty result
    item.probe = (in_key != '0) && (in_op != lph_pkg::OP_NOP);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/lph_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_back
// Probe engine: walks the slot table one slot per cycle, applies the
// request and registers the result beat.
// ----------------------------------------------------------------------------
module lph_back #(
  parameter int TABLE_SIZE = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [lph_pkg::LIMIT_W-1:0]    load_limit,
  output logic                           ready_for_work,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  lph_pkg::lph_req_t              q_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [lph_pkg::VALUE_W-1:0]    out_rval,
  output logic                           out_status
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int SW = lph_pkg::KEY_W + 1;

  lph_pkg::lph_state_t state, state_next;
  lph_pkg::lph_req_t   req;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       n;
  logic                tomb_seen;
  logic [AW-1:0]       tomb_idx;
  logic [lph_pkg::COUNT_W-1:0] claimed;
  logic [AW-1:0]       clr_addr;

  logic [AW-1:0]       raddr;
  logic [SW-1:0]       slot_rdata;
  logic [lph_pkg::VALUE_W-1:0] val_rdata;
  logic                key_we, val_we;
  logic [AW-1:0]       key_waddr, val_waddr;
  logic [SW-1:0]       key_wdata;
  logic [lph_pkg::VALUE_W-1:0] val_wdata;

  logic                out_free;
  logic                s_tomb, s_empty, s_match, last, finish, advance;
  logic                f_hit, f_status;
  logic [lph_pkg::VALUE_W-1:0] f_rval;
  logic                claim_fresh;

  assign out_free       = !out_valid || out_ready;
  assign ready_for_work = (state != lph_pkg::ST_CLEAR);

  // slot word is {tombstone, key}
  assign s_tomb  = slot_rdata[SW-1];
  assign s_empty = (slot_rdata[SW-2:0] == '0) && !s_tomb;
  assign s_match = (slot_rdata[SW-2:0] == req.key);
  assign last    = (n == AW'(TABLE_SIZE - 1));
  assign finish  = s_empty || s_match || last;
  assign advance = (state == lph_pkg::ST_CHECK) && !finish;

  always_comb begin
    if (state == lph_pkg::ST_IDLE) begin
      raddr = q_item.hash[AW-1:0];
    end else if (advance) begin
      raddr = idx + AW'(1);
    end else begin
      raddr = idx;
    end
  end

  lph_ram #(.WIDTH(SW), .DEPTH(TABLE_SIZE)) u_slot_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (slot_rdata)
  );

  lph_ram #(.WIDTH(lph_pkg::VALUE_W), .DEPTH(TABLE_SIZE)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lph_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(TABLE_SIZE - 1)) begin
          state_next = lph_pkg::ST_IDLE;
        end
      end
      lph_pkg::ST_IDLE: begin
        if (q_valid && q_item.probe) begin
          state_next = lph_pkg::ST_CHECK;
        end
      end
      lph_pkg::ST_CHECK: begin
        if (finish && out_free) begin
          state_next = lph_pkg::ST_IDLE;
        end
      end
      default: state_next = lph_pkg::ST_CLEAR;
    endcase
  end

  // outcome of the walk and table updates
  always_comb begin
    logic          tseen;
    logic [AW-1:0] tpos;
    tseen       = tomb_seen || (s_tomb && slot_rdata[SW-2:0] == '0);
    tpos        = tomb_seen ? tomb_idx : idx;
    f_hit       = 1'b0;
    f_status    = 1'b0;
    f_rval      = '0;
    claim_fresh = 1'b0;
    key_we      = 1'b0;
    key_waddr   = idx;
    key_wdata   = '0;
    val_we      = 1'b0;
    val_waddr   = idx;
    val_wdata   = req.wval;
    q_pop       = 1'b0;
    case (state)
      lph_pkg::ST_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_addr;
      end
      lph_pkg::ST_IDLE: begin
        // non-walking requests leave straight from idle
        q_pop = q_valid && (q_item.probe || out_free);
      end
      lph_pkg::ST_CHECK: begin
        if (finish && out_free) begin
          if (s_match && !s_empty) begin
            case (req.op)
              lph_pkg::OP_GET: begin
                f_hit  = 1'b1;
                f_rval = val_rdata;
              end
              lph_pkg::OP_SET: begin
                val_we = 1'b1;
              end
              lph_pkg::OP_ERASE: begin
                f_hit     = 1'b1;
                key_we    = 1'b1;
                key_wdata = {1'b1, {lph_pkg::KEY_W{1'b0}}};
              end
              default: f_hit = 1'b0;
            endcase
          end else if (req.op == lph_pkg::OP_SET) begin
            if (tseen) begin
              // reuse first tombstone passed
              f_hit     = 1'b1;
              key_we    = 1'b1;
              key_waddr = tpos;
              key_wdata = {1'b0, req.key};
              val_we    = 1'b1;
              val_waddr = tpos;
            end else if (s_empty &&
                         (claimed < lph_pkg::COUNT_W'(load_limit))) begin
              f_hit       = 1'b1;
              claim_fresh = 1'b1;
              key_we      = 1'b1;
              key_wdata   = {1'b0, req.key};
              val_we      = 1'b1;
            end else begin
              f_status = 1'b1;
            end
          end
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lph_pkg::ST_CLEAR;
      clr_addr  <= '0;
      claimed   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lph_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (claim_fresh) begin
        claimed <= claimed + lph_pkg::COUNT_W'(1);
      end
      if ((state == lph_pkg::ST_CHECK && finish && out_free) ||
          (state == lph_pkg::ST_IDLE && q_valid && !q_item.probe && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lph_pkg::ST_IDLE && q_pop) begin
      req       <= q_item;
      idx       <= q_item.hash[AW-1:0];
      n         <= '0;
      tomb_seen <= 1'b0;
      tomb_idx  <= '0;
      if (!q_item.probe) begin
        out_hit    <= 1'b0;
        out_rval   <= '0;
        out_status <= 1'b0;
      end
    end else if (advance) begin
      idx <= idx + AW'(1);
      n   <= n + AW'(1);
      if (!tomb_seen && s_tomb && slot_rdata[SW-2:0] == '0) begin
        tomb_seen <= 1'b1;
        tomb_idx  <= idx;
      end
    end else if (state == lph_pkg::ST_CHECK && out_free) begin
      out_hit    <= f_hit;
      out_rval   <= f_rval;
      out_status <= f_status;
    end
  end

endmodule

// ===== hdl/linear_probe_hash_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Open addressing hash table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// walk: the probe engine serves one request at a time, walking the slot memory
//   one slot per cycle through its single read port; a zero key or the unused
//   op code skips the walk and leaves straight from idle
// reset: synchronous; a clearing pass over all TABLE_SIZE slots empties the slot
//   table, and no request beat is taken until it ends; load_limit resets to 48
module linear_probe_hash_map #(
  parameter int TABLE_SIZE = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data,   // load_limit
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,    // key_id, key_hash, write_value
  input  logic [1:0]   s_tuser,    // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata     // hit, read_value, status, zero fill
);

  logic [lph_pkg::LIMIT_W-1:0] load_limit;
  logic              q_valid;
  logic              q_pop;
  lph_pkg::lph_req_t q_item;
  logic              work_ok;
  logic              hit;
  logic              status;
  logic [lph_pkg::VALUE_W-1:0] rval;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= 6'd48;
    end else if (cfg_valid) begin
      load_limit <= cfg_data;
    end
  end

  lph_front u_front (
    .clk      (clk),
    .rst      (rst),
    .enable   (work_ok),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_key   (s_tdata[31:0]),
    .in_hash  (s_tdata[63:32]),
    .in_wval  (s_tdata[127:64]),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  lph_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk            (clk),
    .rst            (rst),
    .load_limit     (load_limit),
    .ready_for_work (work_ok),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_item         (q_item),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_hit        (hit),
    .out_rval       (rval),
    .out_status     (status)
  );

  assign m_tdata = {6'd0, status, rval, hit};

endmodule
